// ===== hw/rtl/mcsu_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsu_pkg
// Shared types, request kinds, reply codes and table layout for the mutex and
// condition variable unit.
// ----------------------------------------------------------------------------
package mcsu_pkg;

    localparam int NUM_TILES = 16;
    localparam int MUX_CAP   = 64;
    localparam int COND_CAP  = 64;
    localparam int NCORES    = 32;

    localparam int TBL_DEPTH  = 64;
    localparam int WMEM_DEPTH = 128;

    // Request kinds.
    localparam logic [2:0] K_MUTEX_INIT = 3'd0;
    localparam logic [2:0] K_LOCK       = 3'd1;
    localparam logic [2:0] K_UNLOCK     = 3'd2;
    localparam logic [2:0] K_COND_INIT  = 3'd3;
    localparam logic [2:0] K_COND_WAIT  = 3'd4;
    localparam logic [2:0] K_SIGNAL     = 3'd5;
    localparam logic [2:0] K_BCAST      = 3'd6;
    localparam logic [2:0] K_BAD        = 3'd7;

    // Reply codes.
    localparam logic [2:0] RC_GRANT    = 3'd0;
    localparam logic [2:0] RC_UNLOCK   = 3'd1;
    localparam logic [2:0] RC_SIGNAL   = 3'd2;
    localparam logic [2:0] RC_BCAST    = 3'd3;
    localparam logic [2:0] RC_MUTEX_ID = 3'd4;
    localparam logic [2:0] RC_COND_ID  = 3'd5;
    localparam logic [2:0] RC_ERROR    = 3'd6;

    typedef struct packed {
        logic       valid;
        logic [4:0] owner;
        logic       ne;
        logic [4:0] head;
        logic [4:0] tail;
    } t_mentry;

    typedef struct packed {
        logic       ne;
        logic [4:0] head;
        logic [4:0] tail;
    } t_centry;

    // The second memory holds condition entries, waiter links and held mutexes.
    function automatic logic [6:0] cond_addr(input logic [5:0] ci);
        return {1'b0, ci};
    endfunction

    function automatic logic [6:0] next_addr(input logic [4:0] w);
        return {2'b10, w};
    endfunction

    function automatic logic [6:0] held_addr(input logic [4:0] w);
        return {2'b11, w};
    endfunction

endpackage

// ===== hw/rtl/mcsu_ram.sv =====
// ----------------------------------------------------------------------------
// mcsu_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mcsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/mutex_condvar_sync_unit.sv =====
// ----------------------------------------------------------------------------
// mutex_condvar_sync_unit
// Lock and condition variable manager. Mutex entries live in one RAM; the
// condition entries, waiter links and held mutexes share a second RAM.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: kind; tdata: tile, type, mutex_index, cond_index, time
// m_axis    out  tuser: reply_code; tdata: dest_tile, dest_type, time, value;
//                tlast: last
//
// One request at a time. A signal wakes at most one waiter and a broadcast up
// to 32, each through serial read-modify-write traffic on the two table RAMs.
// Reset clears the allocation counters and the control state only; the
// tables are written on allocation. A stalled reply holds the sequencer.
// ----------------------------------------------------------------------------
module mutex_condvar_sync_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,  // kind
    input  logic [87:0] s_axis_tdata,  // tile, type, mutex_index, cond_index, time
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [2:0]  m_axis_tuser,  // reply_code
    output logic [79:0] m_axis_tdata,  // dest_tile, dest_type, reply_time, reply_value
    output logic        m_axis_tlast   // last
);
    import mcsu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_LOAD, S_TRY, S_POP, S_NEXT, S_HELD, S_MLOAD, S_CFIN,
        S_REL, S_REL_NEXT, S_GRANT_REL, S_UNLOCK_ACK, S_CW_HELD, S_CW_PUSH,
        S_CW_LINK, S_MINIT, S_CINIT, S_ERR
    } t_state;

    t_state r_state, n_state;

    logic [2:0]  r_kind;
    logic [4:0]  r_core;
    logic [5:0]  r_mi, r_ci;
    logic [63:0] r_time;
    logic [6:0]  r_mcnt, n_mcnt, r_ccnt, n_ccnt;
    t_mentry     r_m, n_m;
    t_centry     r_c, n_c;
    logic [4:0]  r_w, n_w;
    logic [5:0]  r_m2, n_m2;
    logic [5:0]  r_iter, n_iter;

    logic        r_out_valid;
    logic [4:0]  r_out_core;
    logic [2:0]  r_out_code;
    logic [63:0] r_out_time;
    logic [5:0]  r_out_val;
    logic        r_out_last;

    logic        a_we, a_re;
    logic [5:0]  a_waddr, a_raddr;
    t_mentry     a_wdata, a_rdata;
    logic        b_we, b_re;
    logic [6:0]  b_waddr, b_raddr;
    logic [10:0] b_wdata, b_rdata;

    logic        em, em_grant, em_last;
    logic [4:0]  em_dest;
    logic [2:0]  em_code;
    logic [5:0]  em_val;

    logic        out_free, mok, cok, chk_err, owns, is_bc, more;
    t_centry     cw;

    assign out_free = !r_out_valid || m_axis_tready;
    assign mok      = {1'b0, r_mi} < r_mcnt;
    assign cok      = {1'b0, r_ci} < r_ccnt;
    assign owns     = a_rdata.valid && (a_rdata.owner == r_core);
    assign is_bc    = (r_kind == K_BCAST);
    assign more     = r_c.ne && (is_bc ? (r_iter < 6'(NCORES)) : (r_iter == 6'd0));

    always_comb begin
        chk_err = ({1'b0, r_core[3:0]} >= 5'(NUM_TILES));
        unique case (r_kind)
            K_MUTEX_INIT: chk_err = chk_err || (r_mcnt >= 7'(MUX_CAP));
            K_COND_INIT:  chk_err = chk_err || (r_ccnt >= 7'(COND_CAP));
            K_LOCK,
            K_UNLOCK:     chk_err = chk_err || !mok;
            K_COND_WAIT:  chk_err = chk_err || !mok || !cok;
            K_SIGNAL,
            K_BCAST:      chk_err = chk_err || !cok;
            default:      chk_err = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_c     = r_c;
        n_w     = r_w;
        n_m2    = r_m2;
        n_iter  = r_iter;
        n_mcnt  = r_mcnt;
        n_ccnt  = r_ccnt;
        a_we    = 1'b0;
        a_waddr = r_m2;
        a_wdata = r_m;
        a_re    = 1'b0;
        a_raddr = r_mi;
        b_we    = 1'b0;
        b_waddr = cond_addr(r_ci);
        b_wdata = '0;
        b_re    = 1'b0;
        b_raddr = cond_addr(r_ci);
        em       = 1'b0;
        em_dest  = r_core;
        em_code  = RC_ERROR;
        em_grant = 1'b0;
        em_val   = '0;
        em_last  = 1'b1;
        cw       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (chk_err) begin
                    n_state = S_ERR;
                end else if (r_kind == K_MUTEX_INIT) begin
                    n_state = S_MINIT;
                end else if (r_kind == K_COND_INIT) begin
                    n_state = S_CINIT;
                end else begin
                    a_re    = 1'b1;
                    b_re    = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_m    = a_rdata;
                n_c    = t_centry'(b_rdata);
                n_m2   = r_mi;
                n_w    = r_core;
                n_iter = '0;
                priority if (r_kind == K_LOCK) begin
                    n_state = S_TRY;
                end else if (r_kind == K_UNLOCK) begin
                    n_state = owns ? S_REL : S_ERR;
                end else if (r_kind == K_COND_WAIT) begin
                    n_state = owns ? S_CW_HELD : S_ERR;
                end else begin
                    n_state = S_POP;
                end
            end
            S_TRY: begin
                if (!r_m.valid) begin
                    em       = 1'b1;
                    em_dest  = r_w;
                    em_code  = RC_GRANT;
                    em_grant = 1'b1;
                    em_last  = (r_kind == K_LOCK);
                    if (out_free) begin
                        a_we    = 1'b1;
                        a_wdata = '{valid: 1'b1, owner: r_w, ne: r_m.ne,
                                    head: r_m.head, tail: r_m.tail};
                        n_state = (r_kind == K_LOCK) ? S_IDLE : S_POP;
                    end
                end else begin
                    // Mutex held: the core joins the mutex queue.
                    a_we    = 1'b1;
                    a_wdata = '{valid: 1'b1, owner: r_m.owner, ne: 1'b1,
                                head: r_m.ne ? r_m.head : r_w, tail: r_w};
                    if (r_m.ne) begin
                        b_we    = 1'b1;
                        b_waddr = next_addr(r_m.tail);
                        b_wdata = {6'b0, r_w};
                    end
                    n_state = (r_kind == K_LOCK) ? S_IDLE : S_POP;
                end
            end
            S_POP: begin
                if (more) begin
                    n_iter = r_iter + 6'd1;
                    n_w    = r_c.head;
                    b_re   = 1'b1;
                    if (r_c.head == r_c.tail) begin
                        n_c.ne  = 1'b0;
                        b_raddr = held_addr(r_c.head);
                        n_state = S_HELD;
                    end else begin
                        b_raddr = next_addr(r_c.head);
                        n_state = S_NEXT;
                    end
                end else begin
                    n_state = S_CFIN;
                end
            end
            S_NEXT: begin
                n_c.head = b_rdata[4:0];
                b_re     = 1'b1;
                b_raddr  = held_addr(r_w);
                n_state  = S_HELD;
            end
            S_HELD: begin
                n_m2 = b_rdata[5:0];
                if ({1'b0, b_rdata[5:0]} < r_mcnt) begin
                    a_re    = 1'b1;
                    a_raddr = b_rdata[5:0];
                    n_state = S_MLOAD;
                end else begin
                    n_state = S_POP;
                end
            end
            S_MLOAD: begin
                n_m     = a_rdata;
                n_state = S_TRY;
            end
            S_CFIN: begin
                em      = 1'b1;
                em_code = is_bc ? RC_BCAST : RC_SIGNAL;
                if (out_free) begin
                    cw      = '{ne: is_bc ? 1'b0 : r_c.ne, head: r_c.head, tail: r_c.tail};
                    b_we    = 1'b1;
                    b_wdata = 11'(cw);
                    n_state = S_IDLE;
                end
            end
            S_REL: begin
                if (r_m.ne) begin
                    n_w = r_m.head;
                    if (r_m.head == r_m.tail) begin
                        a_we    = 1'b1;
                        a_wdata = '{valid: 1'b1, owner: r_m.head, ne: 1'b0,
                                    head: r_m.head, tail: r_m.tail};
                        n_state = S_GRANT_REL;
                    end else begin
                        b_re    = 1'b1;
                        b_raddr = next_addr(r_m.head);
                        n_state = S_REL_NEXT;
                    end
                end else begin
                    a_we          = 1'b1;
                    a_wdata       = r_m;
                    a_wdata.valid = 1'b0;
                    n_state       = (r_kind == K_UNLOCK) ? S_UNLOCK_ACK : S_IDLE;
                end
            end
            S_REL_NEXT: begin
                a_we    = 1'b1;
                a_wdata = '{valid: 1'b1, owner: r_w, ne: 1'b1,
                            head: b_rdata[4:0], tail: r_m.tail};
                n_state = S_GRANT_REL;
            end
            S_GRANT_REL: begin
                em       = 1'b1;
                em_dest  = r_w;
                em_code  = RC_GRANT;
                em_grant = 1'b1;
                em_last  = (r_kind == K_COND_WAIT);
                if (out_free) begin
                    n_state = (r_kind == K_COND_WAIT) ? S_IDLE : S_UNLOCK_ACK;
                end
            end
            S_UNLOCK_ACK: begin
                em      = 1'b1;
                em_code = RC_UNLOCK;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CW_HELD: begin
                b_we    = 1'b1;
                b_waddr = held_addr(r_core);
                b_wdata = {5'b0, r_mi};
                n_state = S_CW_PUSH;
            end
            S_CW_PUSH: begin
                cw      = '{ne: 1'b1, head: r_c.ne ? r_c.head : r_core, tail: r_core};
                b_we    = 1'b1;
                b_wdata = 11'(cw);
                n_state = r_c.ne ? S_CW_LINK : S_REL;
            end
            S_CW_LINK: begin
                b_we    = 1'b1;
                b_waddr = next_addr(r_c.tail);
                b_wdata = {6'b0, r_core};
                n_state = S_REL;
            end
            S_MINIT: begin
                em      = 1'b1;
                em_code = RC_MUTEX_ID;
                em_val  = r_mcnt[5:0];
                if (out_free) begin
                    a_we    = 1'b1;
                    a_waddr = r_mcnt[5:0];
                    a_wdata = '0;
                    n_mcnt  = r_mcnt + 7'd1;
                    n_state = S_IDLE;
                end
            end
            S_CINIT: begin
                em      = 1'b1;
                em_code = RC_COND_ID;
                em_val  = r_ccnt[5:0];
                if (out_free) begin
                    b_we    = 1'b1;
                    b_waddr = cond_addr(r_ccnt[5:0]);
                    b_wdata = '0;
                    n_ccnt  = r_ccnt + 7'd1;
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                em = 1'b1;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mcnt      <= '0;
            r_ccnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mcnt  <= n_mcnt;
            r_ccnt  <= n_ccnt;
            if (em && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_m    <= n_m;
        r_c    <= n_c;
        r_w    <= n_w;
        r_m2   <= n_m2;
        r_iter <= n_iter;
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_kind <= s_axis_tuser;
            r_core <= {s_axis_tdata[4], s_axis_tdata[3:0]};
            r_mi   <= s_axis_tdata[10:5];
            r_ci   <= s_axis_tdata[16:11];
            r_time <= s_axis_tdata[80:17];
        end
        if (em && out_free) begin
            r_out_core <= em_dest;
            r_out_code <= em_code;
            r_out_time <= em_grant ? r_time : 64'd0;
            r_out_val  <= em_val;
            r_out_last <= em_last;
        end
    end

    mcsu_ram #(.WIDTH(17), .DEPTH(TBL_DEPTH)) u_mutex_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mcsu_ram #(.WIDTH(11), .DEPTH(WMEM_DEPTH)) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_code;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'b0, r_out_val, r_out_time, r_out_core[4], r_out_core[3:0]};
endmodule
